// ===== hdl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the chunked body decoder
// Byte classes passed from the front end to the back end, the decoder phase
// encoding, status and error codes, and the sizes of the word queue.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // limits
  localparam int unsigned SIZE_W = 27;
  localparam int unsigned BODY_W = 32;
  localparam logic [SIZE_W+3:0] MAX_CHUNK_BYTES = 31'd104857600;
  localparam logic [BODY_W-1:0] MAX_BODY_RESET = 32'd1048576;

  // word queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // status codes
  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // error kinds
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_LARGE = 2'd2;

  // decoder phase
  typedef enum logic [13:0] {
    PH_LEAD   = 14'b00000000000001,
    PH_ZERO   = 14'b00000000000010,
    PH_XPFX   = 14'b00000000000100,
    PH_DIGITS = 14'b00000000001000,
    PH_TRAIL  = 14'b00000000010000,
    PH_EXT    = 14'b00000000100000,
    PH_BAD    = 14'b00000001000000,
    PH_DATA   = 14'b00000010000000,
    PH_DCR    = 14'b00000100000000,
    PH_DLF    = 14'b00001000000000,
    PH_DLFBAD = 14'b00010000000000,
    PH_THEAD  = 14'b00100000000000,
    PH_TBODY  = 14'b01000000000000,
    PH_DONE   = 14'b10000000000000
  } phase_t;

  // classified input word
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       hex;
    logic [3:0] hex_val;
    logic       blank;
    logic       cr;
    logic       lf;
    logic       semi;
    logic       zero;
    logic       xch;
  } word_t;

  // size line parser state
  typedef struct packed {
    phase_t            phase;
    logic [SIZE_W-1:0] acc;
    logic              ovf;
    logic              ds;
  } size_t;

endpackage

// ===== hdl/chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// chunked_body_decoder_core: streaming decoder for a chunked request body
// One byte per word in, one result word out per input word.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_data (max body bytes)
//   in       in         in_valid/in_ready     op, in_byte
//   out      out        out_valid/out_ready   consumed, data_valid, data_byte,
//                                             status, error_kind
//
// One word per cycle sustained while the output is taken; an input word
// passes a queue slot, then the decoder state update into the result register.
// The decoder state loop is updated once per word.
// A stalled output fills the two-entry queue, then input ready drops.
// Synchronous reset clears all control state and sets the body limit to 1 MiB.
// ----------------------------------------------------------------------------
module chunked_body_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        consumed,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic [1:0]  error_kind
);

  logic [31:0]    max_body_bytes;
  logic           q_full;
  logic           push;
  logic           pop;
  logic           q_valid;
  cbd_pkg::word_t push_word;
  cbd_pkg::word_t q_word;

  // body limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= cbd_pkg::MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_body_bytes <= cfg_data;
    end
  end

  // front end
  cbd_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  // word queue
  cbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  // decoder
  cbd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .max_body_bytes (max_body_bytes),
    .q_valid        (q_valid),
    .q_word         (q_word),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .consumed       (consumed),
    .data_valid     (data_valid),
    .data_byte      (data_byte),
    .status         (status),
    .error_kind     (error_kind)
  );

`ifndef NO_ASSERTIONS
  // a consumed byte never reports an error
  a_consumed_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && consumed |-> status != cbd_pkg::ST_ERROR)
    else $error("consumed byte reported with error status");

  // decoded data only comes from a consumed byte
  a_data_consumed: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> consumed)
    else $error("data word without consumed byte");

  // error kind is set exactly when status is error
  a_kind_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_kind != cbd_pkg::ERR_NONE) == (status == cbd_pkg::ST_ERROR)))
    else $error("error kind and status disagree");

  // a queued word with a free result register gives a result next cycle
  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    q_valid && !out_valid |=> out_valid)
    else $error("queued word not decoded");
`endif

endmodule

// ===== hdl/cbd_front.sv =====
// ----------------------------------------------------------------------------
// cbd_front: input acceptance and byte classification
// Takes words from the input channel while the queue has room and tags each
// byte with the character classes the decoder needs.
// ----------------------------------------------------------------------------
module cbd_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          push,
  output cbd_pkg::word_t push_word
);

  // accept while the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classify the byte
  always_comb begin
    push_word.op      = op;
    push_word.data    = in_byte;
    push_word.hex     = 1'b0;
    push_word.hex_val = 4'd0;
    if (in_byte >= cbd_pkg::CH_ZERO && in_byte <= cbd_pkg::CH_NINE) begin
      push_word.hex     = 1'b1;
      push_word.hex_val = 4'(in_byte - cbd_pkg::CH_ZERO);
    end else if (in_byte >= cbd_pkg::CH_LO_A && in_byte <= cbd_pkg::CH_LO_F) begin
      push_word.hex     = 1'b1;
      push_word.hex_val = 4'(in_byte - cbd_pkg::CH_LO_A + 8'd10);
    end else if (in_byte >= cbd_pkg::CH_UP_A && in_byte <= cbd_pkg::CH_UP_F) begin
      push_word.hex     = 1'b1;
      push_word.hex_val = 4'(in_byte - cbd_pkg::CH_UP_A + 8'd10);
    end
    push_word.blank = (in_byte == cbd_pkg::CH_SP) || (in_byte == cbd_pkg::CH_TAB);
    push_word.cr    = (in_byte == cbd_pkg::CH_CR);
    push_word.lf    = (in_byte == cbd_pkg::CH_LF);
    push_word.semi  = (in_byte == cbd_pkg::CH_SEMI);
    push_word.zero  = (in_byte == cbd_pkg::CH_ZERO);
    push_word.xch   = (in_byte == cbd_pkg::CH_LO_X) || (in_byte == cbd_pkg::CH_UP_X);
  end

endmodule

// ===== hdl/cbd_queue.sv =====
// ----------------------------------------------------------------------------
// cbd_queue: short word queue between front and back
// A small register queue so the input side and the decoder stall apart.
// ----------------------------------------------------------------------------
module cbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cbd_pkg::word_t push_word,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output cbd_pkg::word_t q_word
);

  cbd_pkg::word_t                     slots [cbd_pkg::QDEPTH];
  logic [cbd_pkg::QPTR_W-1:0]         wr_ptr;
  logic [cbd_pkg::QPTR_W-1:0]         rd_ptr;
  logic [cbd_pkg::QCNT_W-1:0]         count;

  assign full    = (count == cbd_pkg::QCNT_W'(cbd_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_word  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cbd_pkg::QPTR_W'(cbd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cbd_pkg::QPTR_W'(cbd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/cbd_back.sv =====
// ----------------------------------------------------------------------------
// cbd_back: chunked decoding state machine and result register
// Runs one classified word per cycle, unless stalled, through the size line,
// data, data terminator and trailer phases and holds the result until taken.
// ----------------------------------------------------------------------------
module cbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    max_body_bytes,
  input  logic           q_valid,
  input  cbd_pkg::word_t q_word,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           consumed,
  output logic           data_valid,
  output logic [7:0]     data_byte,
  output logic [1:0]     status,
  output logic [1:0]     error_kind
);

  cbd_pkg::phase_t                   phase, phase_next;
  logic [cbd_pkg::SIZE_W-1:0]        acc, acc_next;
  logic                              ovf, ovf_next;
  logic                              ds, ds_next;
  logic [cbd_pkg::SIZE_W-1:0]        remaining, remaining_next;
  logic [cbd_pkg::BODY_W-1:0]        body_count, body_count_next;
  logic [1:0]                        tmatch, tmatch_next;
  logic [1:0]                        err, err_next;

  logic                              r_consumed, r_dvalid;
  logic [7:0]                        r_dbyte;
  logic [1:0]                        r_status, r_kind;

  logic                              fire;
  logic                              body_over;
  logic                              line_large;
  logic [cbd_pkg::SIZE_W-1:0]        rem_dec;
  cbd_pkg::size_t                    sc;
  cbd_pkg::word_t                    w;

  // one content byte of the size line
  function automatic cbd_pkg::size_t size_content(cbd_pkg::phase_t p,
                                                  logic [cbd_pkg::SIZE_W-1:0] a,
                                                  logic o, logic d,
                                                  cbd_pkg::word_t c);
    cbd_pkg::size_t              r;
    logic                        do_digit;
    logic [cbd_pkg::SIZE_W+3:0]  v;
    r.phase  = p;
    r.acc    = a;
    r.ovf    = o;
    r.ds     = d;
    do_digit = 1'b0;
    v        = {a, c.hex_val};
    unique case (p) inside
      cbd_pkg::PH_LEAD: begin
        if (c.blank) begin
          r.phase = p;
        end else if (c.zero) begin
          r.ds    = 1'b1;
          r.acc   = '0;
          r.phase = cbd_pkg::PH_ZERO;
        end else if (c.hex) begin
          do_digit = 1'b1;
        end else begin
          r.phase = c.semi ? cbd_pkg::PH_EXT : cbd_pkg::PH_BAD;
        end
      end
      cbd_pkg::PH_ZERO, cbd_pkg::PH_XPFX, cbd_pkg::PH_DIGITS: begin
        if (p == cbd_pkg::PH_ZERO && c.xch) begin
          r.ds    = 1'b0;
          r.phase = cbd_pkg::PH_XPFX;
        end else if (c.hex) begin
          do_digit = 1'b1;
        end else if (c.blank) begin
          r.phase = cbd_pkg::PH_TRAIL;
        end else begin
          r.phase = c.semi ? cbd_pkg::PH_EXT : cbd_pkg::PH_BAD;
        end
      end
      cbd_pkg::PH_TRAIL: begin
        if (!c.blank) begin
          r.phase = c.semi ? cbd_pkg::PH_EXT : cbd_pkg::PH_BAD;
        end
      end
      default: begin
        r.phase = p;
      end
    endcase
    // accumulate a hex digit, saturating into the overflow flag
    if (do_digit) begin
      r.ds    = 1'b1;
      r.phase = cbd_pkg::PH_DIGITS;
      if (!o) begin
        if (v > cbd_pkg::MAX_CHUNK_BYTES) begin
          r.ovf = 1'b1;
        end else begin
          r.acc = v[cbd_pkg::SIZE_W-1:0];
        end
      end
    end
    return r;
  endfunction

  assign w    = q_word;
  assign fire = q_valid && (!out_valid || out_ready);
  assign pop  = fire;

  // limit checks
  assign body_over  = (body_count > max_body_bytes);
  assign line_large = (({1'b0, body_count} + (cbd_pkg::BODY_W+1)'(acc))
                       > {1'b0, max_body_bytes});
  assign rem_dec    = remaining - 1'b1;
  assign sc         = size_content(phase, acc, ovf, ds, w);

  // next state and result
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    ovf_next        = ovf;
    ds_next         = ds;
    remaining_next  = remaining;
    body_count_next = body_count;
    tmatch_next     = tmatch;
    err_next        = err;
    r_consumed      = 1'b0;
    r_dvalid        = 1'b0;
    r_dbyte         = 8'd0;
    r_status        = cbd_pkg::ST_MORE;
    r_kind          = cbd_pkg::ERR_NONE;
    if (w.op) begin
      // restart for the next request
      phase_next      = cbd_pkg::PH_LEAD;
      acc_next        = '0;
      ovf_next        = 1'b0;
      ds_next         = 1'b0;
      remaining_next  = '0;
      body_count_next = '0;
      tmatch_next     = 2'd0;
      err_next        = cbd_pkg::ERR_NONE;
    end else if (err != cbd_pkg::ERR_NONE) begin
      r_status = cbd_pkg::ST_ERROR;
      r_kind   = err;
    end else if (phase == cbd_pkg::PH_DONE) begin
      r_status = cbd_pkg::ST_DONE;
    end else if (body_over) begin
      err_next = cbd_pkg::ERR_LARGE;
      r_status = cbd_pkg::ST_ERROR;
      r_kind   = cbd_pkg::ERR_LARGE;
    end else begin
      r_consumed = 1'b1;
      unique case (phase) inside
        cbd_pkg::PH_DATA: begin
          r_dvalid        = 1'b1;
          r_dbyte         = w.data;
          body_count_next = body_count + 1'b1;
          remaining_next  = rem_dec;
          if (rem_dec == '0) begin
            phase_next = cbd_pkg::PH_DCR;
          end
        end
        cbd_pkg::PH_DCR: begin
          phase_next = w.cr ? cbd_pkg::PH_DLF : cbd_pkg::PH_DLFBAD;
        end
        cbd_pkg::PH_DLF, cbd_pkg::PH_DLFBAD: begin
          if (phase == cbd_pkg::PH_DLF && w.lf) begin
            phase_next  = cbd_pkg::PH_LEAD;
            acc_next    = '0;
            ovf_next    = 1'b0;
            ds_next     = 1'b0;
            tmatch_next = 2'd0;
          end else begin
            err_next = cbd_pkg::ERR_BAD;
          end
        end
        cbd_pkg::PH_THEAD: begin
          if (tmatch == 2'd1 && w.lf) begin
            tmatch_next = 2'd0;
            phase_next  = cbd_pkg::PH_DONE;
          end else if (tmatch == 2'd0 && w.cr) begin
            tmatch_next = 2'd1;
          end else begin
            phase_next  = cbd_pkg::PH_TBODY;
            tmatch_next = w.cr ? 2'd1 : 2'd0;
          end
        end
        cbd_pkg::PH_TBODY: begin
          // progress through CR LF CR LF
          if ((!tmatch[0] && w.cr) || (tmatch[0] && w.lf)) begin
            if (tmatch == 2'd3) begin
              tmatch_next = 2'd0;
              phase_next  = cbd_pkg::PH_DONE;
            end else begin
              tmatch_next = tmatch + 2'd1;
            end
          end else begin
            tmatch_next = w.cr ? 2'd1 : 2'd0;
          end
        end
        cbd_pkg::PH_LEAD, cbd_pkg::PH_ZERO, cbd_pkg::PH_XPFX, cbd_pkg::PH_DIGITS,
        cbd_pkg::PH_TRAIL, cbd_pkg::PH_EXT, cbd_pkg::PH_BAD: begin
          if (tmatch == 2'd1) begin
            if (w.lf) begin
              // size line end
              tmatch_next = 2'd0;
              if (phase == cbd_pkg::PH_BAD || !ds || ovf) begin
                err_next = cbd_pkg::ERR_BAD;
              end else if (acc == '0) begin
                phase_next = cbd_pkg::PH_THEAD;
              end else if (line_large) begin
                err_next = cbd_pkg::ERR_LARGE;
              end else begin
                remaining_next = acc;
                phase_next     = cbd_pkg::PH_DATA;
              end
            end else begin
              // a lone cr is a stray character
              tmatch_next = w.cr ? 2'd1 : 2'd0;
              phase_next  = (phase == cbd_pkg::PH_EXT) ? cbd_pkg::PH_EXT : cbd_pkg::PH_BAD;
            end
          end else if (w.cr) begin
            tmatch_next = 2'd1;
          end else begin
            phase_next = sc.phase;
            acc_next   = sc.acc;
            ovf_next   = sc.ovf;
            ds_next    = sc.ds;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      if (err_next != cbd_pkg::ERR_NONE) begin
        r_consumed = 1'b0;
        r_dvalid   = 1'b0;
        r_dbyte    = 8'd0;
        r_status   = cbd_pkg::ST_ERROR;
        r_kind     = err_next;
      end else if (phase_next == cbd_pkg::PH_DONE) begin
        r_status = cbd_pkg::ST_DONE;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cbd_pkg::PH_LEAD;
      acc        <= '0;
      ovf        <= 1'b0;
      ds         <= 1'b0;
      remaining  <= '0;
      body_count <= '0;
      tmatch     <= 2'd0;
      err        <= cbd_pkg::ERR_NONE;
    end else if (fire) begin
      phase      <= phase_next;
      acc        <= acc_next;
      ovf        <= ovf_next;
      ds         <= ds_next;
      remaining  <= remaining_next;
      body_count <= body_count_next;
      tmatch     <= tmatch_next;
      err        <= err_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      consumed   <= r_consumed;
      data_valid <= r_dvalid;
      data_byte  <= r_dbyte;
      status     <= r_status;
      error_kind <= r_kind;
    end
  end

endmodule

// ===== tb/sv/tb_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_chunked_body_decoder_core: self-checking bench for the chunked decoder
// Feeds request bodies one byte word at a time over valid/ready, keeps its
// own bit-accurate decoder state to predict every result word, and checks
// the result stream in order. Directed cases come first: a well-formed body,
// a syntax error, both extremes of the body limit and a limit lowered in the
// middle of a body. Random well-formed, broken and noisy bodies follow, under
// several idle and stall patterns and several body limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chunked_body_decoder_core;
  import cbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_LIMIT = 20;

  typedef struct packed {
    logic       consumed;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [1:0] error_kind;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        consumed;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [1:0]  error_kind;

  chunked_body_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .consumed   (consumed),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .status     (status),
    .error_kind (error_kind)
  );

  always #1 clk = ~clk;

  // predicted decoder state
  phase_t            decoder_phase;
  logic [SIZE_W-1:0] size_acc;
  logic              size_ovf;
  logic              digit_seen;
  logic [SIZE_W-1:0] remaining_bytes;
  logic [31:0]       body_total;
  logic [1:0]        term_match;
  logic [1:0]        sticky_err;
  logic [31:0]       body_limit;

  decode_result_t pending_results[$];
  logic [7:0]     body_stream[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned data_results = 0;
  int unsigned done_results = 0;
  int unsigned error_results = 0;
  int unsigned limits_written = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_decoder();
    decoder_phase = PH_LEAD;
    size_acc = '0;
    size_ovf = 1'b0;
    digit_seen = 1'b0;
    remaining_bytes = '0;
    body_total = '0;
    term_match = '0;
    sticky_err = ERR_NONE;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  // accumulate one size digit, latching overflow past the chunk ceiling
  function automatic void add_size_digit(input logic [3:0] d);
    logic [SIZE_W+3:0] wide;
    digit_seen = 1'b1;
    if (!size_ovf) begin
      wide = {size_acc, d};
      if (wide > MAX_CHUNK_BYTES) size_ovf = 1'b1;
      else size_acc = wide[SIZE_W-1:0];
    end
    decoder_phase = PH_DIGITS;
  endfunction

  // one size line character other than the closing cr lf
  function automatic void size_char(input logic [7:0] c);
    int   v;
    logic blank;
    v = hex_digit(c);
    blank = (c == CH_SP) || (c == CH_TAB);
    case (decoder_phase)
      PH_LEAD: begin
        if (blank) return;
        if (c == CH_ZERO) begin
          digit_seen = 1'b1;
          size_acc = '0;
          decoder_phase = PH_ZERO;
          return;
        end
        if (v >= 0) begin
          add_size_digit(v[3:0]);
          return;
        end
        decoder_phase = (c == CH_SEMI) ? PH_EXT : PH_BAD;
        return;
      end
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          digit_seen = 1'b0;
          decoder_phase = PH_XPFX;
          return;
        end
      end
      PH_XPFX, PH_DIGITS: ;
      PH_TRAIL: begin
        if (blank) return;
        decoder_phase = (c == CH_SEMI) ? PH_EXT : PH_BAD;
        return;
      end
      default: return;
    endcase
    if (v >= 0) add_size_digit(v[3:0]);
    else if (blank) decoder_phase = PH_TRAIL;
    else decoder_phase = (c == CH_SEMI) ? PH_EXT : PH_BAD;
  endfunction

  // size line byte: a cr is held back until we know whether lf follows
  function automatic void size_byte(input logic [7:0] c);
    if (term_match == 2'd1) begin
      if (c == CH_LF) begin
        term_match = '0;
        if (decoder_phase == PH_BAD || !digit_seen || size_ovf) sticky_err = ERR_BAD;
        else if (size_acc == '0) decoder_phase = PH_THEAD;
        else if (({1'b0, body_total} + 33'(size_acc)) > {1'b0, body_limit})
          sticky_err = ERR_LARGE;
        else begin
          remaining_bytes = size_acc;
          decoder_phase = PH_DATA;
        end
        return;
      end
      term_match = '0;
      size_char(CH_CR);
    end
    if (c == CH_CR) term_match = 2'd1;
    else size_char(c);
  endfunction

  function automatic decode_result_t decode_word(input logic restart, input logic [7:0] c);
    decode_result_t r;
    logic [7:0]     want_byte;
    r = '0;
    if (restart) begin
      clear_decoder();
    end else if (sticky_err != ERR_NONE) begin
      r.status = ST_ERROR;
      r.error_kind = sticky_err;
    end else if (decoder_phase == PH_DONE) begin
      r.status = ST_DONE;
    end else if (body_total > body_limit) begin
      sticky_err = ERR_LARGE;
      r.status = ST_ERROR;
      r.error_kind = ERR_LARGE;
    end else begin
      r.consumed = 1'b1;
      case (decoder_phase)
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte = c;
          body_total = body_total + 1'b1;
          remaining_bytes = remaining_bytes - 1'b1;
          if (remaining_bytes == '0) decoder_phase = PH_DCR;
        end
        PH_DCR: decoder_phase = (c == CH_CR) ? PH_DLF : PH_DLFBAD;
        PH_DLF, PH_DLFBAD: begin
          if (decoder_phase == PH_DLF && c == CH_LF) begin
            decoder_phase = PH_LEAD;
            size_acc = '0;
            size_ovf = 1'b0;
            digit_seen = 1'b0;
            term_match = '0;
          end else begin
            sticky_err = ERR_BAD;
          end
        end
        PH_THEAD: begin
          if (term_match == 2'd1 && c == CH_LF) begin
            term_match = '0;
            decoder_phase = PH_DONE;
          end else if (term_match == 2'd0 && c == CH_CR) begin
            term_match = 2'd1;
          end else begin
            decoder_phase = PH_TBODY;
            term_match = (c == CH_CR) ? 2'd1 : 2'd0;
          end
        end
        PH_TBODY: begin
          // hunt for cr lf cr lf
          want_byte = term_match[0] ? CH_LF : CH_CR;
          if (c == want_byte) begin
            if (term_match == 2'd3) begin
              term_match = '0;
              decoder_phase = PH_DONE;
            end else begin
              term_match = term_match + 1'b1;
            end
          end else begin
            term_match = (c == CH_CR) ? 2'd1 : 2'd0;
          end
        end
        default: size_byte(c);
      endcase
      if (sticky_err != ERR_NONE) begin
        r = '0;
        r.status = ST_ERROR;
        r.error_kind = sticky_err;
      end else if (decoder_phase == PH_DONE) begin
        r.status = ST_DONE;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input word; the predicted result is queued once it is accepted
  task automatic send_word(input logic restart, input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= restart;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_word(restart, b));
    words_sent++;
  endtask

  task automatic send_stream();
    foreach (body_stream[i]) send_word(1'b0, body_stream[i]);
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_body_limit(input logic [31:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    body_limit = value;
    limits_written++;
  endtask

  // ---------------------------------------------------------------------------
  // body builders
  // ---------------------------------------------------------------------------

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_stream.push_back(s[i]);
  endtask

  task automatic push_crlf();
    body_stream.push_back(CH_CR);
    body_stream.push_back(CH_LF);
  endtask

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  // size line in a random but legal spelling
  task automatic build_size_line(input int unsigned sz);
    string digits;
    digits = $sformatf("%0h", sz);
    for (int i = 0; i < digits.len(); i++)
      if (digits[i] >= CH_LO_A && $urandom_range(1) == 1) digits[i] = digits[i] - 8'd32;
    repeat ($urandom_range(2)) body_stream.push_back(pick_blank());
    if ($urandom_range(3) == 0) push_text($urandom_range(1) ? "0x" : "0X");
    if ($urandom_range(4) == 0) push_text("0");
    push_text(digits);
    repeat ($urandom_range(1)) body_stream.push_back(pick_blank());
    if ($urandom_range(3) == 0) push_text($urandom_range(1) ? ";n=v" : "; ext");
    push_crlf();
  endtask

  task automatic build_trailer();
    string alphabet;
    alphabet = "tk: =";
    if ($urandom_range(1) == 1) begin
      push_crlf();
    end else begin
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(7) == 0) body_stream.push_back(CH_CR);
          else body_stream.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
        end
        push_crlf();
      end
      push_crlf();
    end
  endtask

  // mostly well-formed bodies, the rest carry one kind of fault
  task automatic build_random_body();
    int unsigned flavour, sz, idx;
    logic        bad_term;
    body_stream.delete();
    flavour = $urandom_range(9);
    bad_term = (flavour == 8);
    if (flavour == 6) begin
      // malformed size line
      case ($urandom_range(8))
        0: ;
        1: push_text("0x");
        2: push_text("+5");
        3: push_text("-1");
        4: push_text("5g");
        5: push_text("1 2");
        6: push_text(";ext");
        7: begin
          push_text("7");
          body_stream.push_back(CH_CR);
          push_text("1");
        end
        default: body_stream.push_back(pick_blank());
      endcase
      push_crlf();
    end else if (flavour == 7) begin
      // sizes at and past the chunk ceiling
      case ($urandom_range(3))
        0: push_text("6400000");
        1: push_text("6400001");
        2: push_text("fffffff");
        default: push_text("800000000");
      endcase
      push_crlf();
      repeat ($urandom_range(3)) body_stream.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3)) begin
        sz = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        build_size_line(sz);
        repeat (sz) body_stream.push_back(8'($urandom_range(255)));
        if (bad_term) begin
          case ($urandom_range(2))
            0: begin
              body_stream.push_back(CH_CR);
              body_stream.push_back(8'($urandom_range(255)));
            end
            1: begin
              body_stream.push_back(8'($urandom_range(255)));
              body_stream.push_back(CH_LF);
            end
            default: begin
              body_stream.push_back(8'($urandom_range(255)));
              body_stream.push_back(8'($urandom_range(255)));
            end
          endcase
          bad_term = 1'b0;
        end else begin
          push_crlf();
        end
      end
      build_size_line(0);
      build_trailer();
      if (flavour == 9) begin
        // one byte overwritten, or the body cut short
        idx = $urandom_range(body_stream.size() - 1);
        if ($urandom_range(1) == 1) body_stream[idx] = 8'($urandom_range(255));
        else while (body_stream.size() > idx) void'(body_stream.pop_back());
      end
    end
    // stray bytes after the end are not taken
    repeat ($urandom_range(2)) body_stream.push_back(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  decode_result_t want_result, got_result;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = {consumed, data_valid, data_byte, status, error_kind};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
          $display("%0t: result word with nothing expected: %p", $time, got_result);
      end else begin
        want_result = pending_results.pop_front();
        results_checked++;
        if (got_result !== want_result) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT)
            $display("%0t: mismatch expected %p actual %p", $time, want_result, got_result);
        end
        if (want_result.data_valid) data_results++;
        if (want_result.status == ST_DONE) done_results++;
        if (want_result.status == ST_ERROR) error_results++;
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** chunked_body_decoder_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // well-formed body under the reset limit, then a byte after completion
  task automatic test_basic_body();
    send_word(1'b1, 8'h00);
    body_stream.delete();
    push_text(" 0x2;e");
    push_crlf();
    body_stream.push_back(8'h00);
    body_stream.push_back(8'hff);
    push_crlf();
    push_text("0");
    push_crlf();
    push_crlf();
    push_text("A");
    send_stream();
  endtask

  // sign in the size, judged at the line end, then sticky
  task automatic test_syntax_error();
    send_word(1'b1, 8'hff);
    body_stream.delete();
    push_text("+");
    push_crlf();
    push_text("1");
    send_stream();
  endtask

  task automatic test_limit_extremes();
    write_body_limit(32'h0000_0000);
    send_word(1'b1, 8'h5a);
    body_stream.delete();
    push_text("1");
    push_crlf();
    send_stream();
    send_word(1'b1, 8'ha5);
    body_stream.delete();
    push_text("0");
    push_crlf();
    push_crlf();
    send_stream();
    write_body_limit(32'hffff_ffff);
    send_word(1'b1, 8'h00);
    body_stream.delete();
    push_text("6400000");
    push_crlf();
    push_text("ok");
    send_stream();
    send_word(1'b1, 8'h00);
    body_stream.delete();
    push_text("6400001");
    push_crlf();
    send_stream();
  endtask

  // limit drops below the bytes already delivered
  task automatic test_limit_lowered_midway();
    write_body_limit(MAX_BODY_RESET);
    send_word(1'b1, 8'h00);
    body_stream.delete();
    push_text("4");
    push_crlf();
    push_text("ab");
    send_stream();
    write_body_limit(32'd1);
    send_word(1'b0, "c");
    send_word(1'b0, "d");
  endtask

  task automatic run_traffic_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input logic [31:0] limit, input int unsigned n_words);
    int unsigned stop_at;
    write_body_limit(limit);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // noise, restarts included
        repeat ($urandom_range(1, 6))
          send_word($urandom_range(3) == 0, 8'($urandom_range(255)));
      end else begin
        send_word(1'b1, 8'($urandom_range(255)));
        build_random_body();
        send_stream();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 32'hffff_ffff, 125);
    run_traffic_phase(75, 0, $urandom_range(48), 125);
    run_traffic_phase(0, 75, MAX_BODY_RESET, 125);
    run_traffic_phase(30, 30, $urandom, 125);
  endtask

  initial begin
    clear_decoder();
    body_limit = MAX_BODY_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_basic_body();
    test_syntax_error();
    test_limit_extremes();
    test_limit_lowered_midway();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("run: %0d words in, %0d results checked over %0d body limits",
             words_sent, results_checked, limits_written);
    $display("run: %0d data bytes, %0d complete and %0d error results",
             data_results, done_results, error_results);
    if (fail_count == 0) begin
      $display("** chunked_body_decoder_core: PASSED **");
    end else begin
      $display("** chunked_body_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
